// ===== src/assert_macros.svh =====
// Assertion macros shared by the MMU RTL files.
// Depends on nothing; define ASSERT_OFF to drop all checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assert");
`define ASSERT_ONEHOT(label, sig) \
    label: assert property (@(posedge clk) disable iff (!rst_n) $onehot(sig)) else $error("onehot");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_ONEHOT(label, sig)
`endif
`endif

// ===== src/pmmu_pkg.sv =====
// Types and constants of the paged MMU.
// Used by the controller, the datapath and the top level.
package pmmu_pkg;
    localparam int PS_W   = 13;
    localparam int NP_W   = 5;
    localparam int ADDR_W = 16;
    localparam int CNT_W  = 32;
    localparam int PS_MAX = 4096;
    localparam logic CFG_PAGE_SIZE = 1'b0;
    localparam logic CFG_NUM_PAGES = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_LOOK = 6'b000100,
        S_SCAN = 6'b001000,
        S_UPD  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic look;
        logic scan_step;
        logic update;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic scan_done;
        logic need_scan;
        logic out_taken;
    } stat_t;
endpackage

// ===== src/paged_mmu_with_lru_tlb.sv =====
// Top level of the paged MMU with an LRU TLB and demand paging.
// Depends on pmmu_pkg, pmmu_ctrl and pmmu_dp.
//
// Use: each beat on s_axis carries one 16-bit logical address. The block
// splits it into page and offset, looks up the TLB, reads the page table,
// assigns a frame on a fault and returns one beat on m_axis.
// m_axis_tdata, from bit 0: physical_address[15:0], invalid_address,
// tlb_hit, page_fault, replaced, hit_count, miss_count, fault_count,
// 4 zero bits (120 bits).
// Steps: bit-serial division, a TLB lookup, on a fault a free frame and
// LRU scan over max(PAGES, FRAMES) entries, and an update that registers
// the result for m_axis.
// One address is at work at a time; s_axis_tready is high only when idle.
// The result is held on m_axis until m_axis_tready takes it.
// Reset clears residency, TLB valid bits, recency ranks and counters;
// page_size returns to 256 and num_pages to 16.
// cfg_we writes cfg_data to register cfg_index (0 page_size, 1 num_pages);
// the user must do so only while the block is idle; it is not enforced.
module paged_mmu_with_lru_tlb
    import pmmu_pkg::*;
#(
    parameter int TLB_ENTRIES = 4,
    parameter int FRAMES      = 8,
    parameter int PAGES       = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // logical_address
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [119:0] m_axis_tdata,   // physical_address, invalid_address, tlb_hit,
                                         // page_fault, replaced, hit_count,
                                         // miss_count, fault_count, pad[3:0]
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [12:0]  cfg_data
);
    cmd_t  cmd;
    stat_t stat;
    logic [ADDR_W-1:0] phys;
    logic inv, hit, flt, rep;
    logic [CNT_W-1:0] hc, mc, fc;

    pmmu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .stat     (stat),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    pmmu_dp #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .FRAMES      (FRAMES),
        .PAGES       (PAGES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_index),
        .cfg_data  (cfg_data),
        .addr_in   (s_axis_tdata),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .phys      (phys),
        .invalid   (inv),
        .hit       (hit),
        .fault     (flt),
        .repl      (rep),
        .hit_cnt   (hc),
        .miss_cnt  (mc),
        .fault_cnt (fc)
    );

    assign m_axis_tdata = {4'd0, fc, mc, hc, rep, flt, hit, inv, phys};
endmodule

// ===== src/pmmu_ctrl.sv =====
// Controller state machine of the paged MMU.
// Depends on pmmu_pkg; drives the datapath by cmd_t, reads stat_t.
`include "assert_macros.svh"
module pmmu_ctrl
    import pmmu_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  stat_t stat,
    output logic  in_ready,
    output cmd_t  cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid)
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                    state_next = S_LOOK;
            end
            S_LOOK:
            begin
                cmd.look = 1'b1;
                state_next = stat.need_scan ? S_SCAN : S_UPD;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                    state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.emit = 1'b1;
                if (stat.out_taken)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    `ASSERT_ONEHOT(a_state_onehot, state_reg)
    `ASSERT_CLK(a_load_to_div, cmd.load |=> state_reg == S_DIV)
    `ASSERT_CLK(a_upd_to_out, state_reg == S_UPD |=> state_reg == S_OUT)
endmodule

// ===== src/pmmu_dp.sv =====
// Datapath of the paged MMU: divider, TLB, page table, LRU, counters.
// Depends on pmmu_pkg; steered by cmd_t from pmmu_ctrl.
`include "assert_macros.svh"
module pmmu_dp
    import pmmu_pkg::*;
#(
    parameter int TLB_ENTRIES = 4,
    parameter int FRAMES      = 8,
    parameter int PAGES       = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output stat_t             stat,
    input  logic              cfg_we,
    input  logic              cfg_idx,
    input  logic [PS_W-1:0]   cfg_data,
    input  logic [ADDR_W-1:0] addr_in,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [ADDR_W-1:0] phys,
    output logic              invalid,
    output logic              hit,
    output logic              fault,
    output logic              repl,
    output logic [CNT_W-1:0]  hit_cnt,
    output logic [CNT_W-1:0]  miss_cnt,
    output logic [CNT_W-1:0]  fault_cnt
);
    localparam int TW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int RW = PW;
    localparam int SW = (PAGES > FRAMES) ? PW + 1 : FW + 1;
    localparam int SCAN_N = (PAGES > FRAMES) ? PAGES : FRAMES;

    logic [PS_W-1:0] ps_reg;
    logic [NP_W-1:0] np_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ps_reg <= PS_W'(256);
            np_reg <= NP_W'(16);
        end
        else if (cfg_we)
        begin
            if (cfg_idx == CFG_PAGE_SIZE)
                ps_reg <= cfg_data;
            else
                np_reg <= cfg_data[NP_W-1:0];
        end
    end

    logic [PS_W-1:0] ps_c;
    logic [8:0]      np_c;
    always_comb
    begin
        ps_c = ps_reg;
        if (ps_reg == '0)
            ps_c = PS_W'(1);
        else if (ps_reg > PS_W'(PS_MAX))
            ps_c = PS_W'(PS_MAX);
        np_c = 9'(np_reg);
        if (np_reg == '0)
            np_c = 9'd1;
        else if (9'(np_reg) > 9'(PAGES))
            np_c = 9'(PAGES);
    end

    // restoring divider, one quotient bit a cycle
    logic [ADDR_W-1:0] quo_reg;
    logic [PS_W:0]     rem_reg;
    logic [4:0]        dcnt_reg;
    logic [PS_W:0]     trial;
    assign trial = {rem_reg[PS_W-1:0], quo_reg[ADDR_W-1]};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            quo_reg  <= addr_in;
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg + 5'd1;
            if (trial >= {1'b0, ps_c})
            begin
                rem_reg <= trial - {1'b0, ps_c};
                quo_reg <= {quo_reg[ADDR_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[ADDR_W-2:0], 1'b0};
            end
        end
    end
    assign stat.div_done = dcnt_reg == 5'(ADDR_W - 1);

    logic [TLB_ENTRIES-1:0] tv_reg;
    logic [PW-1:0] tp_mem [TLB_ENTRIES];
    logic [FW-1:0] tf_mem [TLB_ENTRIES];
    logic [TW-1:0] tr_reg [TLB_ENTRIES];
    logic [PAGES-1:0]  pres_reg;
    logic [FRAMES-1:0] fused_reg;
    logic [FW-1:0] pt_mem [PAGES];
    logic [RW-1:0] pr_reg [PAGES];
    logic [CNT_W-1:0] hc_reg, mc_reg, fc_reg;

    logic          inv_reg, hit_reg, flt_reg, rep_reg, wasres_reg;
    logic [PW-1:0] pg_reg;
    logic [TW-1:0] he_reg;
    logic [FW-1:0] fr_reg;
    logic [SW-1:0] sc_reg;
    logic          ffound_reg, vfound_reg;
    logic [PW-1:0] vic_reg;
    logic [ADDR_W-1:0] phys_reg;
    logic          ov_reg;
    logic [PW-1:0] pg_q;
    assign pg_q = quo_reg[PW-1:0];

    logic          lk_hit;
    logic [TW-1:0] lk_e;
    always_comb
    begin
        lk_hit = 1'b0;
        lk_e   = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
            if (tv_reg[i] && tp_mem[i] == pg_q)
            begin
                lk_hit = 1'b1;
                lk_e   = TW'(i);
            end
    end
    logic lk_inv;
    assign lk_inv = {7'd0, quo_reg} >= {14'd0, np_c};

    assign stat.need_scan = !lk_inv && !lk_hit && !pres_reg[pg_q];
    assign stat.scan_done = sc_reg >= SW'(SCAN_N - 1);
    assign stat.out_taken = out_ready;

    // new frame: a free frame if one was found, else the LRU victim's frame
    logic [FW-1:0] nf;
    logic          vic_use;
    always_comb
    begin
        vic_use = !ffound_reg && vfound_reg;
        nf = ffound_reg ? fr_reg : (vfound_reg ? pt_mem[vic_reg] : '0);
    end

    logic [FW-1:0] fin_fr;
    assign fin_fr = hit_reg ? tf_mem[he_reg] : (flt_reg ? nf : pt_mem[pg_reg]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tv_reg    <= '0;
            pres_reg  <= '0;
            fused_reg <= '0;
            hc_reg <= '0;
            mc_reg <= '0;
            fc_reg <= '0;
            ov_reg <= 1'b0;
            for (int i = 0; i < TLB_ENTRIES; i++)
                tr_reg[i] <= '0;
            for (int i = 0; i < PAGES; i++)
                pr_reg[i] <= '0;
        end
        else
        begin
            if (cmd.look)
            begin
                inv_reg    <= lk_inv;
                hit_reg    <= !lk_inv && lk_hit;
                flt_reg    <= stat.need_scan;
                rep_reg    <= 1'b0;
                wasres_reg <= pres_reg[pg_q];
                pg_reg     <= pg_q;
                he_reg     <= lk_e;
                sc_reg     <= '0;
                ffound_reg <= 1'b0;
                vfound_reg <= 1'b0;
                fr_reg     <= '0;
                vic_reg    <= '0;
            end
            if (cmd.scan_step)
            begin
                sc_reg <= sc_reg + SW'(1);
                if (sc_reg < SW'(FRAMES) && !ffound_reg
                    && !fused_reg[sc_reg[FW-1:0]])
                begin
                    ffound_reg <= 1'b1;
                    fr_reg     <= sc_reg[FW-1:0];
                end
                if (sc_reg < SW'(PAGES) && pres_reg[sc_reg[PW-1:0]]
                    && (!vfound_reg || pr_reg[sc_reg[PW-1:0]] > pr_reg[vic_reg]))
                begin
                    vfound_reg <= 1'b1;
                    vic_reg    <= sc_reg[PW-1:0];
                end
            end
            if (cmd.update && !inv_reg)
            begin : upd
                logic [TLB_ENTRIES-1:0] v;
                logic [TW-1:0]          r [TLB_ENTRIES];
                logic [TW-1:0]          dr;
                logic                   dropped;
                logic [TW-1:0]          sl;
                logic                   full;
                v = tv_reg;
                for (int i = 0; i < TLB_ENTRIES; i++)
                    r[i] = tr_reg[i];
                dr = '0;
                dropped = 1'b0;
                sl = '0;
                full = 1'b1;
                if (hit_reg)
                begin
                    hc_reg <= hc_reg + 1'b1;
                    for (int i = 0; i < TLB_ENTRIES; i++)
                        if (TW'(i) != he_reg && v[i] && r[i] < tr_reg[he_reg])
                            r[i] = r[i] + 1'b1;
                    r[he_reg] = '0;
                end
                else
                begin
                    mc_reg <= mc_reg + 1'b1;
                    if (flt_reg)
                    begin
                        fc_reg <= fc_reg + 1'b1;
                        if (vic_use)
                        begin
                            rep_reg <= 1'b1;
                            pres_reg[vic_reg] <= 1'b0;
                            for (int i = TLB_ENTRIES - 1; i >= 0; i--)
                                if (v[i] && tp_mem[i] == vic_reg)
                                begin
                                    dropped = 1'b1;
                                    dr = TW'(i);
                                end
                            if (dropped)
                            begin
                                v[dr] = 1'b0;
                                for (int j = 0; j < TLB_ENTRIES; j++)
                                    if (v[j] && r[j] > tr_reg[dr])
                                        r[j] = r[j] - 1'b1;
                            end
                        end
                        fused_reg[nf] <= 1'b1;
                        pt_mem[pg_reg] <= nf;
                    end
                    for (int i = TLB_ENTRIES - 1; i >= 0; i--)
                        if (!v[i])
                        begin
                            full = 1'b0;
                            sl = TW'(i);
                        end
                    if (full)
                    begin
                        sl = '0;
                        for (int i = 1; i < TLB_ENTRIES; i++)
                            if (r[i] > r[sl])
                                sl = TW'(i);
                        v[sl] = 1'b0;
                    end
                    for (int i = 0; i < TLB_ENTRIES; i++)
                        if (v[i])
                            r[i] = r[i] + 1'b1;
                    tp_mem[sl] <= pg_reg;
                    tf_mem[sl] <= fin_fr;
                    v[sl] = 1'b1;
                    r[sl] = '0;
                end
                tv_reg <= v;
                for (int i = 0; i < TLB_ENTRIES; i++)
                    tr_reg[i] <= r[i];
                for (int q = 0; q < PAGES; q++)
                    if (PW'(q) != pg_reg && pres_reg[q]
                        && !(vic_use && flt_reg && !hit_reg && PW'(q) == vic_reg)
                        && (!wasres_reg || pr_reg[q] < pr_reg[pg_reg]))
                        pr_reg[q] <= pr_reg[q] + 1'b1;
                pr_reg[pg_reg] <= '0;
                pres_reg[pg_reg] <= 1'b1;
                phys_reg <= ADDR_W'({13'd0, fin_fr} * {3'd0, ps_c} + {3'd0, rem_reg[PS_W-1:0]});
            end
            else if (cmd.update)
                phys_reg <= '0;
            if (cmd.update)
                ov_reg <= 1'b1;
            else if (cmd.emit && out_ready)
                ov_reg <= 1'b0;
        end
    end

    assign out_valid = ov_reg;
    assign phys      = phys_reg;
    assign invalid   = inv_reg;
    assign hit       = hit_reg;
    assign fault     = flt_reg;
    assign repl      = rep_reg;
    assign hit_cnt   = hc_reg;
    assign miss_cnt  = mc_reg;
    assign fault_cnt = fc_reg;

    `ASSERT_CLK(a_flags_excl, out_valid |-> !(hit && fault) && !(invalid && hit))
    `ASSERT_CLK(a_repl_fault, out_valid && repl |-> fault)
    `ASSERT_CLK(a_ov_emit, out_valid && !out_ready |=> out_valid)
endmodule

// ===== tb/sv/mmu_checker.sv =====
// Address translation checker for the paged MMU: watches the address, result
// and config channels, predicts each result and compares it field by field.
// Depends on pmmu_pkg for the config register indexes.
`timescale 1ns / 100ps

module mmu_checker
    import pmmu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [119:0] m_axis_tdata,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [12:0]  cfg_data,
    output int           errors,
    output int           pending
);
    localparam int TLB_N  = 4;
    localparam int FRM_N  = 8;
    localparam int PAGE_N = 16;

    typedef struct packed {
        logic [15:0] phys;
        logic        invalid;
        logic        hit;
        logic        fault;
        logic        replaced;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] faults;
    } xlat_t;

    logic [12:0] page_size_r;
    logic [4:0]  num_pages_r;
    int          ptab[PAGE_N];
    bit          resident[PAGE_N];
    bit          frame_busy[FRM_N];
    int          page_rank[PAGE_N];
    int          tlb_pg[TLB_N];
    int          tlb_fr[TLB_N];
    bit          tlb_ok[TLB_N];
    int          tlb_rank[TLB_N];
    logic [31:0] hit_tot, miss_tot, fault_tot;
    xlat_t       xlat_q[$];

    assign pending = xlat_q.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic clear_state();
        page_size_r = 13'd256;
        num_pages_r = 5'd16;
        for (int i = 0; i < PAGE_N; i++)
        begin
            resident[i] = 0;
            page_rank[i] = 0;
            ptab[i] = 0;
        end
        for (int i = 0; i < FRM_N; i++)
            frame_busy[i] = 0;
        for (int i = 0; i < TLB_N; i++)
        begin
            tlb_ok[i] = 0;
            tlb_rank[i] = 0;
        end
        hit_tot = 0;
        miss_tot = 0;
        fault_tot = 0;
    endtask

    task automatic tlb_drop(input int pg);
        int r;
        for (int i = 0; i < TLB_N; i++)
        begin
            if (tlb_ok[i] && tlb_pg[i] == pg)
            begin
                r = tlb_rank[i];
                tlb_ok[i] = 0;
                for (int j = 0; j < TLB_N; j++)
                    if (tlb_ok[j] && tlb_rank[j] > r)
                        tlb_rank[j]--;
                return;
            end
        end
    endtask

    task automatic tlb_insert(input int pg, input int fr);
        int slot;
        slot = TLB_N;
        for (int i = TLB_N - 1; i >= 0; i--)
            if (!tlb_ok[i])
                slot = i;
        if (slot == TLB_N)
        begin
            slot = 0;
            for (int i = 1; i < TLB_N; i++)
                if (tlb_rank[i] > tlb_rank[slot])
                    slot = i;
            tlb_ok[slot] = 0;
        end
        for (int i = 0; i < TLB_N; i++)
            if (tlb_ok[i])
                tlb_rank[i]++;
        tlb_pg[slot] = pg;
        tlb_fr[slot] = fr;
        tlb_ok[slot] = 1;
        tlb_rank[slot] = 0;
    endtask

    task automatic translate(input logic [15:0] addr, output xlat_t res);
        int ps, np, pg, off, fr, f, v, r;
        bit was_res;
        ps = (page_size_r == 0) ? 1 : (page_size_r > 4096) ? 4096 : page_size_r;
        np = (num_pages_r == 0) ? 1 : (num_pages_r > PAGE_N) ? PAGE_N : num_pages_r;
        pg = addr / ps;
        off = addr % ps;
        fr = 0;
        res = '0;
        if (pg >= np)
            res.invalid = 1;
        else
        begin
            was_res = resident[pg];
            for (int i = 0; i < TLB_N; i++)
            begin
                if (!res.hit && tlb_ok[i] && tlb_pg[i] == pg)
                begin
                    res.hit = 1;
                    fr = tlb_fr[i];
                    r = tlb_rank[i];
                    for (int j = 0; j < TLB_N; j++)
                        if (j != i && tlb_ok[j] && tlb_rank[j] < r)
                            tlb_rank[j]++;
                    tlb_rank[i] = 0;
                end
            end
            if (res.hit)
                hit_tot++;
            else
            begin
                miss_tot++;
                if (!was_res)
                begin
                    res.fault = 1;
                    fault_tot++;
                    f = FRM_N;
                    for (int i = FRM_N - 1; i >= 0; i--)
                        if (!frame_busy[i])
                            f = i;
                    if (f == FRM_N)
                    begin
                        v = PAGE_N;
                        for (int i = 0; i < PAGE_N; i++)
                            if (resident[i] && (v == PAGE_N || page_rank[i] > page_rank[v]))
                                v = i;
                        f = 0;
                        if (v != PAGE_N)
                        begin
                            f = ptab[v] % FRM_N;
                            resident[v] = 0;
                            tlb_drop(v);
                            res.replaced = 1;
                        end
                    end
                    fr = f;
                    frame_busy[f] = 1;
                    ptab[pg] = f;
                end
                else
                    fr = ptab[pg];
                tlb_insert(pg, fr);
            end
            r = page_rank[pg];
            for (int q = 0; q < PAGE_N; q++)
                if (q != pg && resident[q] && (!was_res || page_rank[q] < r))
                    page_rank[q]++;
            page_rank[pg] = 0;
            resident[pg] = 1;
            res.phys = 16'((fr * ps + off) & 16'hFFFF);
        end
        res.hits = hit_tot;
        res.misses = miss_tot;
        res.faults = fault_tot;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        xlat_t want;
        if (!rst_n)
        begin
            clear_state();
            xlat_q.delete();
            errors = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_PAGE_SIZE)
                    page_size_r = cfg_data;
                else
                    num_pages_r = cfg_data[4:0];
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                translate(s_axis_tdata, want);
                xlat_q.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (xlat_q.size() == 0)
                    report("unexpected beat", 0, 0);
                else
                begin
                    want = xlat_q.pop_front();
                    if (m_axis_tdata[15:0] !== want.phys)
                        report("physical_address", m_axis_tdata[15:0], want.phys);
                    if (m_axis_tdata[16] !== want.invalid)
                        report("invalid_address", m_axis_tdata[16], want.invalid);
                    if (m_axis_tdata[17] !== want.hit)
                        report("tlb_hit", m_axis_tdata[17], want.hit);
                    if (m_axis_tdata[18] !== want.fault)
                        report("page_fault", m_axis_tdata[18], want.fault);
                    if (m_axis_tdata[19] !== want.replaced)
                        report("replaced", m_axis_tdata[19], want.replaced);
                    if (m_axis_tdata[51:20] !== want.hits)
                        report("hit_count", m_axis_tdata[51:20], want.hits);
                    if (m_axis_tdata[83:52] !== want.misses)
                        report("miss_count", m_axis_tdata[83:52], want.misses);
                    if (m_axis_tdata[115:84] !== want.faults)
                        report("fault_count", m_axis_tdata[115:84], want.faults);
                    if (m_axis_tdata[119:116] !== 4'd0)
                        report("pad bits", m_axis_tdata[119:116], 0);
                end
            end
        end
    end
endmodule

// ===== tb/sv/testbench.sv =====
// Top of the paged MMU testbench: clock, reset, address and config stimulus,
// back-pressure, watchdog and verdict. Depends on pmmu_pkg, the MMU RTL and mmu_checker.
`timescale 1ns / 100ps

module testbench;
    import pmmu_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_WAIT = 60;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [15:0]  s_axis_tdata;    // logical_address
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [119:0] m_axis_tdata;    // physical_address, invalid_address, tlb_hit,
                                   // page_fault, replaced, hit_count,
                                   // miss_count, fault_count, pad[3:0]
    logic         cfg_we;
    logic         cfg_index;
    logic [12:0]  cfg_data;
    int           errors;
    int           pending;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           quiet_cycles;
    int           eff_ps;
    int           eff_np;

    paged_mmu_with_lru_tlb DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    mmu_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic send_beat(input logic [15:0] addr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= addr;
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic drop_valid();
        s_axis_tvalid <= 0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [12:0] ps, input logic [4:0] np);
        drop_valid();
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_we <= 1;
        cfg_index <= CFG_PAGE_SIZE;
        cfg_data <= ps;
        @(posedge clk);
        cfg_index <= CFG_NUM_PAGES;
        cfg_data <= {8'd0, np};
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
        eff_ps = (ps == 0) ? 1 : (ps > 4096) ? 4096 : ps;
        eff_np = (np == 0) ? 1 : (np > 16) ? 16 : np;
    endtask

    function automatic logic [15:0] pick_address();
        int pg;
        int a;
        if ($urandom_range(99) < 15)
            return 16'($urandom_range(65535));
        pg = $urandom_range(eff_np - 1);
        if ($urandom_range(99) < 60)
            pg = pg % ((eff_np < 10) ? eff_np : 10);
        a = pg * eff_ps + $urandom_range(eff_ps - 1);
        if (a > 65535)
            a = $urandom_range(65535);
        return 16'(a);
    endfunction

    task automatic random_setting();
        logic [12:0] ps;
        logic [4:0]  np;
        case ($urandom_range(7))
            0: ps = 13'd0;
            1: ps = 13'd1;
            2: ps = 13'd4096;
            3: ps = 13'd8191;
            4: ps = 13'd256;
            default: ps = 13'($urandom_range(4096, 1));
        endcase
        case ($urandom_range(5))
            0: np = 5'd0;
            1: np = 5'd1;
            2: np = 5'd31;
            3: np = 5'd16;
            default: np = 5'($urandom_range(16, 1));
        endcase
        set_config(ps, np);
    endtask

    initial
    begin
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        m_axis_tready = 0;
        cfg_we = 0;
        cfg_index = CFG_PAGE_SIZE;
        cfg_data = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        eff_ps = 256;
        eff_np = 16;
        rst_n = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // fill every frame, hit, then force LRU eviction
        send_beat(16'h0000);
        send_beat(16'hFFFF);
        send_beat(16'h00FF);
        for (int p = 1; p < 10; p++)
            send_beat(16'(p * 256 + p));
        send_beat(16'h0010);
        send_beat(16'h0920);
        send_beat(16'h0230);
        send_beat(16'h0F00);
        set_config(13'd4096, 5'd16);
        send_beat(16'hFFFF);
        send_beat(16'hF000);
        set_config(13'd0, 5'd0);
        send_beat(16'h0000);
        send_beat(16'h0001);
        set_config(13'd8191, 5'd31);
        send_beat(16'h8ABC);
        send_beat(16'h7FFF);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 66 : 0;
            recv_stall_pct = (phase == 0) ? 66 : (phase == 1) ? 18 : 0;
            for (int k = 0; k < 4; k++)
            begin
                random_setting();
                for (int n = 0; n < 100; n++)
                    send_beat(pick_address());
            end
        end

        drop_valid();
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+src
src/pmmu_pkg.sv
src/pmmu_ctrl.sv
src/pmmu_dp.sv
src/paged_mmu_with_lru_tlb.sv
tb/sv/mmu_checker.sv
tb/sv/testbench.sv
